[sv/tfbb_pkg.sv]
// shared types, constants and helpers for the temporal frame blend blur
`timescale 1ns / 1ps

package tfbb_pkg;

  // frame store geometry
  localparam int unsigned FRAME_WORDS = 131072;
  localparam int unsigned ADDR_W      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int unsigned FILL_W      = $clog2(FRAME_WORDS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_WORDS - 1);

  // pixel word
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned WORD_W  = BYTE_W * NUM_LANES;

  // store contents after reset: bytes 128, 0, 128, 0 from byte0 up
  localparam logic [WORD_W-1:0] STORE_RESET_WORD = 32'h0080_0080;

  // luma-range clamp and full weight
  localparam logic [BYTE_W:0]   PIX_LO   = 9'd16;
  localparam logic [BYTE_W:0]   PIX_HI   = 9'd235;
  localparam logic [BYTE_W-1:0] FULL_WEIGHT = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_AMOUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 1'b1;
  localparam int unsigned CFG_DATA_W = 8;

  // pixel formats
  localparam logic FMT_RGBA = 1'b0;
  localparam logic FMT_UYVY = 1'b1;

  localparam logic [BYTE_W-1:0] BLUR_RESET = 8'd0;
  localparam logic              FMT_RESET  = FMT_UYVY;

  // per-lane control
  typedef struct packed {
    logic [BYTE_W-1:0] blur;
    logic              blend;
  } lane_ctrl_t;

  // which bytes are blended, bit k for byte k
  function automatic logic [NUM_LANES-1:0] blend_mask(input logic fmt);
    logic [NUM_LANES-1:0] mask;
    if (fmt == FMT_RGBA) begin
      mask = 4'b0111;
    end else begin
      mask = 4'b1010;
    end
    return mask;
  endfunction

endpackage

[sv/tfbb_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tfbb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tfbb_lane.sv]
// one byte lane: weighted blend of input and stored byte with clamp
`timescale 1ns / 1ps

module tfbb_lane (
  input  tfbb_pkg::lane_ctrl_t          ctrl_i,
  input  logic [tfbb_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic [tfbb_pkg::BYTE_W-1:0]   st_byte_i,
  output logic [tfbb_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [tfbb_pkg::BYTE_W-1:0]   st_byte_o
);

  localparam int unsigned BW = tfbb_pkg::BYTE_W;

  logic [BW-1:0]   in_weight;
  logic [2*BW-1:0] prod_in;
  logic [2*BW-1:0] prod_st;
  logic [BW:0]     sum;
  logic [BW-1:0]   blended;

  assign in_weight = tfbb_pkg::FULL_WEIGHT - ctrl_i.blur;
  assign prod_in   = {{BW{1'b0}}, in_byte_i} * {{BW{1'b0}}, in_weight};
  assign prod_st   = {{BW{1'b0}}, st_byte_i} * {{BW{1'b0}}, ctrl_i.blur};
  assign sum       = {1'b0, prod_in[2*BW-1:BW]} + {1'b0, prod_st[2*BW-1:BW]};

  always_comb begin
    if (sum < tfbb_pkg::PIX_LO) begin
      blended = tfbb_pkg::PIX_LO[BW-1:0];
    end else if (sum > tfbb_pkg::PIX_HI) begin
      blended = tfbb_pkg::PIX_HI[BW-1:0];
    end else begin
      blended = sum[BW-1:0];
    end
  end

  // passed bytes keep their stored copy untouched
  assign out_byte_o = ctrl_i.blend ? blended : in_byte_i;
  assign st_byte_o  = ctrl_i.blend ? blended : st_byte_i;

endmodule

[sv/temporal_frame_blend_blur_top.sv]
// temporal frame blend blur: four byte lanes over a frame store read-modify-write
// an accepted input beat is held in stage 1 while the store is read, then registered into the output register
// throughput: 1 beat per cycle while the output is not stalled, set by the store ram (one read and one write a cycle,
// last write forwarded to cover back-to-back hits on the same word)
// reset: store reads as the 128/0 pattern until written, tracked by a fill mark; no clearing pass
`timescale 1ns / 1ps

module temporal_frame_blend_blur_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [tfbb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tfbb_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input pixel stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tfbb_pkg::WORD_W-1:0]           s_axis_tdata,  // byte0, byte1, byte2, byte3
  input  logic                                  s_axis_tuser,  // start_of_frame
  // output pixel stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [tfbb_pkg::WORD_W-1:0]           m_axis_tdata   // out0, out1, out2, out3
);

  localparam int unsigned AW = tfbb_pkg::ADDR_W;
  localparam int unsigned FW = tfbb_pkg::FILL_W;
  localparam int unsigned WW = tfbb_pkg::WORD_W;
  localparam int unsigned BW = tfbb_pkg::BYTE_W;
  localparam int unsigned NL = tfbb_pkg::NUM_LANES;

  // configuration registers
  logic [BW-1:0] blur_q;
  logic          fmt_q;

  // address and fill mark
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] cur_addr;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] s1_addr_inc;

  // stage 1: store read in flight / blend
  logic          s1_vld_q, s1_vld_d;
  logic [WW-1:0] s1_data_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_init_q;   // entry already written since reset

  // last write, forwarded on a same-address read
  logic          wr_vld_q;
  logic [AW-1:0] wr_addr_q;
  logic [WW-1:0] wr_data_q;

  // output register
  logic          m_vld_q, m_vld_d;
  logic [WW-1:0] m_data_q;

  logic          s_fire;
  logic          s1_adv;
  logic          fwd_hit;
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] stored;
  logic [WW-1:0] st_new;
  logic [WW-1:0] out_word;
  logic [NL-1:0] mask;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur_q <= tfbb_pkg::BLUR_RESET;
      fmt_q  <= tfbb_pkg::FMT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfbb_pkg::CFG_BLUR_AMOUNT:  blur_q <= cfg_wdata_i;
        tfbb_pkg::CFG_PIXEL_FORMAT: fmt_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: stage 1 frees when its beat moves to the output register
  // ---------------------------------------------------------------------------
  assign s1_adv        = s1_vld_q && (!m_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || !m_vld_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // start of frame rewinds the store address before this beat
  assign cur_addr = s_axis_tuser ? '0 : addr_q;
  assign addr_d   = s_fire ? ((cur_addr == tfbb_pkg::LAST_ADDR) ? '0 : cur_addr + AW'(1))
                           : addr_q;

  // addresses only step up by one or rewind to zero, so written words always
  // form a prefix of the store and a high-water mark tells written from fresh
  assign s1_addr_inc = FW'(s1_addr_q) + FW'(1);
  assign fill_d      = (s1_adv && (s1_addr_inc > fill_q)) ? s1_addr_inc : fill_q;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (s_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (s1_adv) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      fill_q   <= '0;
      s1_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
      wr_vld_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      fill_q   <= fill_d;
      s1_vld_q <= s1_vld_d;
      m_vld_q  <= m_vld_d;
      if (s1_adv) begin
        wr_vld_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_data_q <= s_axis_tdata;
      s1_addr_q <= cur_addr;
      s1_init_q <= (FW'(cur_addr) < fill_q);
    end
    if (s1_adv) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= st_new;
      m_data_q  <= out_word;
    end
  end

  // ---------------------------------------------------------------------------
  // frame store
  // ---------------------------------------------------------------------------
  tfbb_ram #(
    .WIDTH (WW),
    .DEPTH (tfbb_pkg::FRAME_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (st_new),
    .re_i    (s_fire),
    .raddr_i (cur_addr),
    .rdata_o (ram_rdata)
  );

  // the ram misses a write made in the same cycle as the read; the last write
  // is the only one that can be that late
  assign fwd_hit = wr_vld_q && (wr_addr_q == s1_addr_q);

  always_comb begin
    if (fwd_hit) begin
      stored = wr_data_q;
    end else if (s1_init_q) begin
      stored = ram_rdata;
    end else begin
      stored = tfbb_pkg::STORE_RESET_WORD;
    end
  end

  // ---------------------------------------------------------------------------
  // byte lanes and merge: whole word written back so untouched bytes persist
  // ---------------------------------------------------------------------------
  assign mask = tfbb_pkg::blend_mask(fmt_q);

  for (genvar k = 0; k < NL; k++) begin : g_lane
    tfbb_pkg::lane_ctrl_t ctrl;
    assign ctrl.blur  = blur_q;
    assign ctrl.blend = mask[k];

    tfbb_lane u_lane (
      .ctrl_i     (ctrl),
      .in_byte_i  (s1_data_q[k*BW +: BW]),
      .st_byte_i  (stored[k*BW +: BW]),
      .out_byte_o (out_word[k*BW +: BW]),
      .st_byte_o  (st_new[k*BW +: BW])
    );
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(tfbb_pkg::FRAME_WORDS))
    else $error("fill mark beyond store depth");

  a_fwd_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> (FW'(wr_addr_q) < fill_q))
    else $error("last written word lies outside the fill mark");

  a_accept_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s1_vld_q) |-> s1_adv)
    else $error("beat accepted over an occupied stage");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_vld_q) |-> $past(s1_adv))
    else $error("output beat without a stage 1 transfer");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && m_vld_q && !m_axis_tready) |=> (s1_vld_q && m_vld_q))
    else $error("stalled beat dropped");

endmodule
